// File: rtl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants of the draw command sorter
// Record layout, channel payloads, operation codes, draw kinds and sizes.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SUBMIT = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_INDEXED = 2'd1,
    KIND_PLAIN   = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DRAIN = 2'd1,
    ST_SUM   = 2'd2
  } state_e;

  localparam logic [0:0] REG_INV_BUF = 1'b0;
  localparam logic [0:0] REG_INV_TEX = 1'b1;

  typedef struct packed {
    logic [15:0] vb;
    logic [15:0] tex;
    logic [15:0] ib;
    logic [31:0] icount;
    logic [31:0] istart;
    logic [31:0] voff;
    logic [31:0] vcount;
    logic [31:0] vstart;
    logic [15:0] tag;
  } rec_t;

  // command channel payload
  typedef struct packed {
    op_e         operation;
    logic [15:0] vertex_buffer;
    logic [15:0] texture;
    logic [15:0] index_buffer;
    logic [31:0] index_count;
    logic [31:0] index_start;
    logic [31:0] vertex_offset;
    logic [31:0] vertex_count;
    logic [31:0] vertex_start;
    logic [15:0] object_tag;
  } draw_cmd_t;

  // result channel payload
  typedef struct packed {
    logic        bind_vertex;
    logic        bind_index;
    logic        bind_texture_flag;
    logic [15:0] out_vertex_buffer;
    logic [15:0] out_index_buffer;
    logic [15:0] out_texture;
    kind_e       draw_kind;
    logic [31:0] draw_count;
    logic [31:0] draw_start;
    logic [31:0] out_vertex_offset;
    logic [15:0] out_object_tag;
    logic        last;
  } draw_res_t;

  // control from the top to every cell
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [47:0] rec_key(rec_t r);
    return {r.vb, r.tex, r.ib};
  endfunction

endpackage

// File: rtl/dcs_if.sv
// ----------------------------------------------------------------------------
// dcs_if: valid/ready channels
// Command and result stream channels, one payload per transfer.
// ----------------------------------------------------------------------------
interface dcs_cmd_if;
  logic               valid;
  logic               ready;
  dcs_pkg::draw_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcs_res_if;
  logic               valid;
  logic               ready;
  dcs_pkg::draw_res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dcs_cell.sv
// ----------------------------------------------------------------------------
// dcs_cell: one slot of the sorted record chain
// Holds one record; on insert takes the new record, keeps its own, or takes
// the left neighbor's; on shift takes the right neighbor's record.
// ----------------------------------------------------------------------------
module dcs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcs_pkg::cell_ctrl_t ctrl_i,
  input  dcs_pkg::rec_t       new_rec_i,
  input  dcs_pkg::rec_t       left_rec_i,
  input  logic                left_vld_i,
  input  logic                left_goes_i,
  input  dcs_pkg::rec_t       right_rec_i,
  input  logic                right_vld_i,
  output dcs_pkg::rec_t       rec_o,
  output logic                vld_o,
  output logic                goes_o
);
  dcs_pkg::rec_t rec_q;
  logic          vld_q;
  logic          greater;

  // stable: new record goes after equal keys
  assign greater = vld_q && (dcs_pkg::rec_key(rec_q) > dcs_pkg::rec_key(new_rec_i));
  assign goes_o  = greater || !vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.insert) begin
      // only the first empty slot fills, the valid run grows by one
      vld_q <= vld_q || left_vld_i;
    end else if (ctrl_i.shift) begin
      vld_q <= right_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (greater) begin
        rec_q <= (left_vld_i && left_goes_i) ? left_rec_i : new_rec_i;
      end else if (!vld_q && !(left_vld_i && left_goes_i)) begin
        rec_q <= new_rec_i;
      end else if (!vld_q) begin
        rec_q <= left_rec_i;
      end
    end else if (ctrl_i.shift) begin
      rec_q <= right_rec_i;
    end
  end

  assign rec_o = rec_q;
  assign vld_o = vld_q;
endmodule

// File: rtl/dcs_emit.sv
// ----------------------------------------------------------------------------
// dcs_emit: bind tracking and result formatting
// Turns the head record into a result, tracks bound handles and totals.
// ----------------------------------------------------------------------------
module dcs_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           step_i,
  input  dcs_pkg::rec_t  rec_i,
  input  logic [15:0]    inv_buf_i,
  input  logic [15:0]    inv_tex_i,
  output logic           bind_vertex_o,
  output logic           bind_index_o,
  output logic           bind_texture_o,
  output dcs_pkg::kind_e kind_o,
  output logic [31:0]    count_o,
  output logic [31:0]    start_o,
  output logic [31:0]    voff_o,
  output logic [31:0]    draws_o,
  output logic [31:0]    tbinds_o
);
  logic [15:0] bvb_q, bib_q, btex_q;
  logic [31:0] draws_q, tbinds_q;
  logic        ib_ok;

  assign ib_ok          = rec_i.ib != inv_buf_i;
  assign bind_vertex_o  = rec_i.vb != bvb_q;
  assign bind_index_o   = ib_ok && (rec_i.ib != bib_q);
  assign bind_texture_o = rec_i.tex != btex_q;

  always_comb begin
    kind_o  = dcs_pkg::KIND_NONE;
    count_o = '0;
    start_o = '0;
    voff_o  = '0;
    if (ib_ok && rec_i.icount != '0) begin
      kind_o  = dcs_pkg::KIND_INDEXED;
      count_o = rec_i.icount;
      start_o = rec_i.istart;
      voff_o  = rec_i.voff;
    end else if (rec_i.vcount != '0) begin
      kind_o  = dcs_pkg::KIND_PLAIN;
      count_o = rec_i.vcount;
      start_o = rec_i.vstart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draws_q  <= '0;
      tbinds_q <= '0;
      bvb_q    <= '0;
      bib_q    <= '0;
      btex_q   <= '0;
    end else if (start_i) begin
      draws_q  <= '0;
      tbinds_q <= '0;
      bvb_q    <= inv_buf_i;
      bib_q    <= inv_buf_i;
      btex_q   <= inv_tex_i;
    end else if (step_i) begin
      draws_q <= draws_q + 32'd1;
      bvb_q   <= rec_i.vb;
      if (bind_index_o) begin
        bib_q <= rec_i.ib;
      end
      if (bind_texture_o) begin
        btex_q   <= rec_i.tex;
        tbinds_q <= tbinds_q + 32'd1;
      end
    end
  end

  assign draws_o  = draws_q;
  assign tbinds_o = tbinds_q;
endmodule

// File: rtl/draw_command_sorter.sv
// ----------------------------------------------------------------------------
// draw_command_sorter: sorted draw record store with bind elimination
// Records are kept sorted in a chain of cells; flush drains them in order.
// ----------------------------------------------------------------------------
// Clear and submit: one transfer per cycle while idle and the output is free
// (sorted insertion into the cell chain in a single step). Flush: a result per
// stored record and a summary, one per cycle through the output register while
// it is not stalled; the chain rotates so the store keeps its sorted order. No
// new item during a flush. Reset: store empty, both invalid codes 0xFFFF.
module draw_command_sorter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  dcs_cmd_if.sink     in_ch,
  dcs_res_if.source   out_ch
);
  localparam int unsigned N = dcs_pkg::QueueDepth;

  logic [15:0] inv_buf_q, inv_tex_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_buf_q <= 16'hFFFF;
      inv_tex_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dcs_pkg::REG_INV_BUF: inv_buf_q <= cfg_data_i;
        dcs_pkg::REG_INV_TEX: inv_tex_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dcs_pkg::state_e state_q, state_d;
  logic [dcs_pkg::CntW-1:0] cnt_q, rem_q;
  logic out_vld_q;
  logic out_free, in_fire;
  dcs_pkg::rec_t new_rec;
  dcs_pkg::cell_ctrl_t ctrl;
  dcs_pkg::rec_t rec_w [N+1];
  logic vld_w [N+1];
  logic goes_w [N+1];
  logic start, step;

  assign out_free = !out_vld_q || out_ch.ready;
  assign in_ch.ready = (state_q == dcs_pkg::ST_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign new_rec.vb     = in_ch.data.vertex_buffer;
  assign new_rec.tex    = in_ch.data.texture;
  assign new_rec.ib     = in_ch.data.index_buffer;
  assign new_rec.icount = in_ch.data.index_count;
  assign new_rec.istart = in_ch.data.index_start;
  assign new_rec.voff   = in_ch.data.vertex_offset;
  assign new_rec.vcount = in_ch.data.vertex_count;
  assign new_rec.vstart = in_ch.data.vertex_start;
  assign new_rec.tag    = in_ch.data.object_tag;

  assign start = in_fire && in_ch.data.operation == dcs_pkg::OP_FLUSH;
  assign step  = state_q == dcs_pkg::ST_DRAIN && out_free;

  always_comb begin
    ctrl.clear  = in_fire && in_ch.data.operation == dcs_pkg::OP_CLEAR;
    ctrl.insert = in_fire && in_ch.data.operation == dcs_pkg::OP_SUBMIT &&
                  cnt_q < dcs_pkg::CntW'(N);
    // during drain the head record rotates to the tail slot of the valid run
    ctrl.shift  = step;
  end

  // left of the head cell: the new record, seen as a valid slot that stays
  assign rec_w[0]  = new_rec;
  assign vld_w[0]  = 1'b1;
  assign goes_w[0] = 1'b0;

  // rotation: cells shift left, the cell at index cnt-1 takes the head
  for (genvar g = 0; g < N; g++) begin : g_cell
    dcs_pkg::rec_t rr;
    logic          rv;
    if (g == N - 1) begin : g_tail
      assign rr = rec_w[1];
    end else begin : g_body
      assign rr = (dcs_pkg::CntW'(g + 1) == cnt_q) ? rec_w[1] : rec_w[g+2];
    end
    assign rv = dcs_pkg::CntW'(g + 1) <= cnt_q;
    dcs_cell u_cell (
      .clk_i, .rst_ni,
      .ctrl_i     (ctrl),
      .new_rec_i  (new_rec),
      .left_rec_i (rec_w[g]),
      .left_vld_i (vld_w[g]),
      .left_goes_i(goes_w[g]),
      .right_rec_i(rr),
      .right_vld_i(rv),
      .rec_o      (rec_w[g+1]),
      .vld_o      (vld_w[g+1]),
      .goes_o     (goes_w[g+1])
    );
  end

  logic bv, bi, bt;
  dcs_pkg::kind_e kind;
  logic [31:0] cnt_o, st_o, voff_o, draws, tbinds;
  dcs_emit u_emit (
    .clk_i, .rst_ni,
    .start_i(start), .step_i(step), .rec_i(rec_w[1]),
    .inv_buf_i(inv_buf_q), .inv_tex_i(inv_tex_q),
    .bind_vertex_o(bv), .bind_index_o(bi), .bind_texture_o(bt),
    .kind_o(kind), .count_o(cnt_o), .start_o(st_o), .voff_o(voff_o),
    .draws_o(draws), .tbinds_o(tbinds)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcs_pkg::ST_IDLE:  if (start) state_d = (cnt_q == '0) ? dcs_pkg::ST_SUM : dcs_pkg::ST_DRAIN;
      dcs_pkg::ST_DRAIN: if (step && rem_q == dcs_pkg::CntW'(1)) state_d = dcs_pkg::ST_SUM;
      dcs_pkg::ST_SUM:   if (out_free) state_d = dcs_pkg::ST_IDLE;
      default:           state_d = dcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dcs_pkg::ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.clear) cnt_q <= '0;
      else if (ctrl.insert) cnt_q <= cnt_q + 1'b1;
      if (start) rem_q <= cnt_q;
      else if (step) rem_q <= rem_q - 1'b1;
      if (out_free) out_vld_q <= step || state_q == dcs_pkg::ST_SUM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_ch.data.bind_vertex       <= bv;
      out_ch.data.bind_index        <= bi;
      out_ch.data.bind_texture_flag <= bt;
      out_ch.data.out_vertex_buffer <= rec_w[1].vb;
      out_ch.data.out_index_buffer  <= rec_w[1].ib;
      out_ch.data.out_texture       <= rec_w[1].tex;
      out_ch.data.draw_kind         <= kind;
      out_ch.data.draw_count        <= cnt_o;
      out_ch.data.draw_start        <= st_o;
      out_ch.data.out_vertex_offset <= voff_o;
      out_ch.data.out_object_tag    <= rec_w[1].tag;
      out_ch.data.last              <= 1'b0;
    end else if (state_q == dcs_pkg::ST_SUM && out_free) begin
      out_ch.data.bind_vertex       <= 1'b0;
      out_ch.data.bind_index        <= 1'b0;
      out_ch.data.bind_texture_flag <= 1'b0;
      out_ch.data.out_vertex_buffer <= '0;
      out_ch.data.out_index_buffer  <= '0;
      out_ch.data.out_texture       <= '0;
      out_ch.data.draw_kind         <= dcs_pkg::KIND_SUMMARY;
      out_ch.data.draw_count        <= draws;
      out_ch.data.draw_start        <= tbinds;
      out_ch.data.out_vertex_offset <= '0;
      out_ch.data.out_object_tag    <= '0;
      out_ch.data.last              <= 1'b1;
    end
  end

  assign out_ch.valid = out_vld_q;
endmodule
